// File: hdl/hsv2rgb_pkg.sv
`timescale 1ns / 1ps

package hsv2rgb_pkg;

  localparam int HUE_W  = 16;
  localparam int LVL_W  = 9;
  localparam int FRAC_W = 25;
  localparam int COMP_W = 33;
  localparam int CHAN_W = 8;

  localparam logic [LVL_W-1:0]    LVL_ONE   = 9'd256;
  localparam logic [18:0]         HUE_SCALE = 19'd6;
  localparam logic [FRAC_W-1:0]   UNIT      = 25'h100_0000;
  localparam logic [HUE_W:0]      TURN      = 17'h1_0000;
  localparam logic [COMP_W+7:0]   CHAN_MAX  = 41'd255;

  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_t;

  typedef struct packed {
    logic                valid;
    sector_t             sector;
    logic [LVL_W-1:0]    sat;
    logic [LVL_W-1:0]    val;
    logic [FRAC_W-1:0]   fs;
    logic [FRAC_W-1:0]   gs;
  } prod_t;

  typedef struct packed {
    logic                valid;
    logic [COMP_W-1:0]   red;
    logic [COMP_W-1:0]   green;
    logic [COMP_W-1:0]   blue;
  } comp_t;

endpackage

// File: hdl/hsv2rgb_front.sv
`timescale 1ns / 1ps

module hsv2rgb_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic [hsv2rgb_pkg::HUE_W-1:0]     in_hue,
  input  logic [hsv2rgb_pkg::LVL_W-1:0]     in_saturation,
  input  logic [hsv2rgb_pkg::LVL_W-1:0]     in_brightness,
  output hsv2rgb_pkg::prod_t                prod
);
  import hsv2rgb_pkg::*;

  logic              s1_valid_r;
  sector_t           s1_sector_r;
  logic [HUE_W-1:0]  s1_frac_r;
  logic [LVL_W-1:0]  s1_sat_r;
  logic [LVL_W-1:0]  s1_val_r;

  logic [18:0]       hue6;
  logic [LVL_W-1:0]  sat_nxt;
  logic [LVL_W-1:0]  val_nxt;
  logic [HUE_W:0]    frac_rest;
  prod_t             prod_nxt;
  prod_t             prod_r;

  assign hue6    = 19'(in_hue) * HUE_SCALE;
  assign sat_nxt = (in_saturation > LVL_ONE) ? LVL_ONE : in_saturation;
  assign val_nxt = (in_brightness > LVL_ONE) ? LVL_ONE : in_brightness;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
    end
    s1_sector_r <= sector_t'(hue6[18:16]);
    s1_frac_r   <= hue6[HUE_W-1:0];
    s1_sat_r    <= sat_nxt;
    s1_val_r    <= val_nxt;
  end

  assign frac_rest = TURN - {1'b0, s1_frac_r};

  always_comb begin
    prod_nxt        = '0;
    prod_nxt.valid  = s1_valid_r;
    prod_nxt.sector = s1_sector_r;
    prod_nxt.sat    = s1_sat_r;
    prod_nxt.val    = s1_val_r;
    prod_nxt.fs     = FRAC_W'(s1_frac_r) * FRAC_W'(s1_sat_r);
    prod_nxt.gs     = FRAC_W'(frac_rest) * FRAC_W'(s1_sat_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_r.valid <= 1'b0;
    end else begin
      prod_r.valid <= prod_nxt.valid;
    end
    prod_r.sector <= prod_nxt.sector;
    prod_r.sat    <= prod_nxt.sat;
    prod_r.val    <= prod_nxt.val;
    prod_r.fs     <= prod_nxt.fs;
    prod_r.gs     <= prod_nxt.gs;
  end

  assign prod = prod_r;

endmodule

// File: hdl/hsv2rgb_mix.sv
`timescale 1ns / 1ps

module hsv2rgb_mix (
  input  logic                clk,
  input  logic                rst_n,
  input  hsv2rgb_pkg::prod_t  prod,
  output hsv2rgb_pkg::comp_t  comp
);
  import hsv2rgb_pkg::*;

  logic [FRAC_W-1:0] mq;
  logic [FRAC_W-1:0] mt;
  logic [LVL_W-1:0]  sat_inv;
  logic [COMP_W-1:0] nv;
  logic [COMP_W-1:0] np;
  logic [COMP_W-1:0] nq;
  logic [COMP_W-1:0] nt;
  comp_t             comp_nxt;
  comp_t             comp_r;

  assign mq      = UNIT - prod.fs;
  assign mt      = UNIT - prod.gs;
  assign sat_inv = LVL_ONE - prod.sat;
  assign nv      = COMP_W'(prod.val) << 24;
  assign np      = (COMP_W'(prod.val) * COMP_W'(sat_inv)) << 16;
  assign nq      = COMP_W'(prod.val) * COMP_W'(mq);
  assign nt      = COMP_W'(prod.val) * COMP_W'(mt);

  always_comb begin
    comp_nxt       = '0;
    comp_nxt.valid = prod.valid;
    unique case (prod.sector)
      SEC_RY: begin
        comp_nxt.red = nv; comp_nxt.green = nt; comp_nxt.blue = np;
      end
      SEC_YG: begin
        comp_nxt.red = nq; comp_nxt.green = nv; comp_nxt.blue = np;
      end
      SEC_GC: begin
        comp_nxt.red = np; comp_nxt.green = nv; comp_nxt.blue = nt;
      end
      SEC_CB: begin
        comp_nxt.red = np; comp_nxt.green = nq; comp_nxt.blue = nv;
      end
      SEC_BM: begin
        comp_nxt.red = nt; comp_nxt.green = np; comp_nxt.blue = nv;
      end
      default: begin
        comp_nxt.red = nv; comp_nxt.green = np; comp_nxt.blue = nq;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comp_r.valid <= 1'b0;
    end else begin
      comp_r.valid <= comp_nxt.valid;
    end
    comp_r.red   <= comp_nxt.red;
    comp_r.green <= comp_nxt.green;
    comp_r.blue  <= comp_nxt.blue;
  end

  assign comp = comp_r;

endmodule

// File: hdl/hsv2rgb_scale.sv
`timescale 1ns / 1ps

module hsv2rgb_scale (
  input  logic                              clk,
  input  logic                              rst_n,
  input  hsv2rgb_pkg::comp_t                comp,
  output logic                              out_valid,
  output logic [hsv2rgb_pkg::CHAN_W-1:0]    out_red,
  output logic [hsv2rgb_pkg::CHAN_W-1:0]    out_green,
  output logic [hsv2rgb_pkg::CHAN_W-1:0]    out_blue
);
  import hsv2rgb_pkg::*;

  logic [COMP_W+7:0] red_w;
  logic [COMP_W+7:0] green_w;
  logic [COMP_W+7:0] blue_w;
  logic              valid_r;
  logic [CHAN_W-1:0] red_r;
  logic [CHAN_W-1:0] green_r;
  logic [CHAN_W-1:0] blue_r;

  assign red_w   = (COMP_W+8)'(comp.red) * CHAN_MAX;
  assign green_w = (COMP_W+8)'(comp.green) * CHAN_MAX;
  assign blue_w  = (COMP_W+8)'(comp.blue) * CHAN_MAX;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= comp.valid;
    end
    red_r   <= red_w[39:32];
    green_r <= green_w[39:32];
    blue_r  <= blue_w[39:32];
  end

  assign out_valid = valid_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

endmodule

// File: hdl/hsv_to_rgb_pixel.sv
`timescale 1ns / 1ps

// channel   ports                                             transfer
// input     start, busy, in_hue, in_saturation, in_brightness  start && !busy
// result    out_valid, out_red, out_green, out_blue           out_valid, one cycle
//
// one pixel per clock; each result is registered at the end of every stage below
// stages: hue scale and clamp, fraction products, brightness multiply and sector
//   select, times-255 scaling
// busy stays low, a new pixel may start in every cycle
// synchronous reset clears the valid bits only; data registers are not reset

module hsv_to_rgb_pixel (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [hsv2rgb_pkg::HUE_W-1:0]     in_hue,
  input  logic [hsv2rgb_pkg::LVL_W-1:0]     in_saturation,
  input  logic [hsv2rgb_pkg::LVL_W-1:0]     in_brightness,
  output logic                              out_valid,
  output logic [hsv2rgb_pkg::CHAN_W-1:0]    out_red,
  output logic [hsv2rgb_pkg::CHAN_W-1:0]    out_green,
  output logic [hsv2rgb_pkg::CHAN_W-1:0]    out_blue
);
  import hsv2rgb_pkg::*;

  logic  in_xfer;
  prod_t prod;
  comp_t comp;

  assign busy    = 1'b0;
  assign in_xfer = start && !busy;

  hsv2rgb_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_xfer),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_brightness (in_brightness),
    .prod          (prod)
  );

  hsv2rgb_mix u_mix (
    .clk   (clk),
    .rst_n (rst_n),
    .prod  (prod),
    .comp  (comp)
  );

  hsv2rgb_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .comp      (comp),
    .out_valid (out_valid),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue)
  );

endmodule
